// ===== sv/rwsc_pkg.sv =====
// Shared widths, constants and register indexes of the step cost block.
package rwsc_pkg;

  localparam int unsigned DIV_W = 28;
  localparam int unsigned DVS_W = 16;

  localparam logic signed [16:0] PI_Q      = 17'sd12868;
  localparam logic signed [16:0] HALF_PI_Q = 17'sd6434;
  localparam logic [15:0] GAIN_MAX = 16'hFFFF;
  localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_TRANS_LO = 3'd0;
  localparam logic [2:0] REG_TRANS_HI = 3'd1;
  localparam logic [2:0] REG_ROT_LO   = 3'd2;
  localparam logic [2:0] REG_ROT_HI   = 3'd3;
  localparam logic [2:0] REG_RESET_P  = 3'd4;

  localparam logic [15:0] TRANS_LO_RST = 16'd3523;
  localparam logic [15:0] TRANS_HI_RST = 16'd5161;
  localparam logic [15:0] ROT_LO_RST   = 16'd2744;
  localparam logic [15:0] ROT_HI_RST   = 16'd5079;
  localparam logic [31:0] RESET_P_RST  = 32'd327680;

endpackage

// ===== sv/rwsc_if.sv =====
// Request and result channel interfaces of the step cost block.
interface rwsc_req_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] virt_heading;
  logic signed [14:0] phys_heading;
  logic [15:0]        virt_len;
  logic signed [14:0] virt_step_heading;
  logic [15:0]        phys_len;
  logic signed [14:0] phys_step_heading;
  modport source (output valid, virt_heading, phys_heading, virt_len, virt_step_heading,
                  phys_len, phys_step_heading, input ready);
  modport sink (input valid, virt_heading, phys_heading, virt_len, virt_step_heading,
                phys_len, phys_step_heading, output ready);
endinterface

interface rwsc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_cost;
  logic        saturated;
  modport source (output valid, step_cost, saturated, input ready);
  modport sink (input valid, step_cost, saturated, output ready);
endinterface

// ===== sv/rwsc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module rwsc_div #(
  parameter int unsigned NW = 28,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quotient_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [1:NW-1];
  logic [NW-1:0] dvd_q  [1:NW-1];
  logic [DW-1:0] dvs_q  [1:NW-1];
  logic [NW-1:0] quo_q  [1:NW-1];
  logic [SW-1:0] side_q [1:NW-1];
  logic [NW-1:0] quo_out_q;
  logic [SW-1:0] side_out_q;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_k;
    logic [NW-1:0] dvd_k;
    logic [DW-1:0] dvs_k;
    logic [NW-1:0] quo_k;
    logic [SW-1:0] side_k;
    logic [DW:0]   trial;
    logic          ge;
    logic [NW-1:0] quo_d;
    if (k == 0) begin : g_first
      assign rem_k  = '0;
      assign dvd_k  = dividend_i;
      assign dvs_k  = divisor_i;
      assign quo_k  = '0;
      assign side_k = side_i;
    end else begin : g_next
      assign rem_k  = rem_q[k];
      assign dvd_k  = dvd_q[k];
      assign dvs_k  = dvs_q[k];
      assign quo_k  = quo_q[k];
      assign side_k = side_q[k];
    end
    assign trial = {rem_k, dvd_k[NW-1]};
    assign ge    = trial >= {1'b0, dvs_k};
    assign quo_d = {quo_k[NW-2:0], ge};
    if (k < NW - 1) begin : g_mid
      logic [DW:0] diff;
      logic [DW-1:0] rem_d;
      assign diff  = trial - {1'b0, dvs_k};
      assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1]  <= rem_d;
          dvd_q[k+1]  <= {dvd_k[NW-2:0], 1'b0};
          dvs_q[k+1]  <= dvs_k;
          quo_q[k+1]  <= quo_d;
          side_q[k+1] <= side_k;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_out_q  <= quo_d;
          side_out_q <= side_k;
        end
      end
    end
  end

  assign quotient_o = quo_out_q;
  assign side_o     = side_out_q;

endmodule

// ===== sv/redirected_walk_step_cost_top.sv =====
// Top level of the redirected walk step cost pipeline.
// The request channel req_i carries one candidate step: current and step headings
// (Q3.12 radians) and virtual and physical step lengths (Q8.8).
// The result channel res_o returns one Q16.16 cost per request and a saturation flag.
// Gains are computed by two pipelined dividers producing one quotient bit per stage.
// Each request passes 28 divider stages and then four stages for the gain limits,
// the squares, the length product and the sums. The pipeline accepts one request
// per cycle while the result is not stalled. Band limits and the reset penalty are
// written through cfg_we_i, cfg_idx_i and cfg_data_i; index i selects register i.
// The user must write them only while no request is in flight; this is not enforced.
// Reset clears all valid bits and loads the default limits and penalty.
// When the receiver stalls, the whole pipeline holds and req_i.ready drops, so no
// request is lost or repeated; bubbles in the pipeline are not squeezed out.
module redirected_walk_step_cost_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rwsc_req_if.sink    req_i,
  rwsc_res_if.source  res_o
);
  import rwsc_pkg::*;

  logic [15:0] trans_lo_q, trans_hi_q, rot_lo_q, rot_hi_q;
  logic [31:0] reset_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_lo_q <= TRANS_LO_RST;
      trans_hi_q <= TRANS_HI_RST;
      rot_lo_q   <= ROT_LO_RST;
      rot_hi_q   <= ROT_HI_RST;
      reset_p_q  <= RESET_P_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRANS_LO: trans_lo_q <= cfg_data_i[15:0];
        REG_TRANS_HI: trans_hi_q <= cfg_data_i[15:0];
        REG_ROT_LO:   rot_lo_q   <= cfg_data_i[15:0];
        REG_ROT_HI:   rot_hi_q   <= cfg_data_i[15:0];
        REG_RESET_P:  reset_p_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || res_o.ready;
  assign req_i.ready = en;

  // Turn angles and divider operands.
  logic signed [16:0] vr, pr, vr1, pr1, vr2, pr2, vneg, pneg;
  logic               refl;
  logic [14:0]        vmag, pmag;
  always_comb begin
    vr   = {{2{req_i.virt_step_heading[14]}}, req_i.virt_step_heading}
         - {{2{req_i.virt_heading[14]}}, req_i.virt_heading};
    pr   = {{2{req_i.phys_step_heading[14]}}, req_i.phys_step_heading}
         - {{2{req_i.phys_heading[14]}}, req_i.phys_heading};
    vr1  = vr[16] ? vr + PI_Q : vr;
    pr1  = pr[16] ? pr + PI_Q : pr;
    refl = vr1 > HALF_PI_Q;
    vr2  = refl ? PI_Q - vr1 : vr1;
    pr2  = refl ? PI_Q - pr1 : pr1;
    vneg = -vr2;
    pneg = -pr2;
    vmag = vr2[16] ? vneg[14:0] : vr2[14:0];
    pmag = pr2[16] ? pneg[14:0] : pr2[14:0];
  end

  logic [DIV_W-1:0] tq, rq;
  logic [16:0]      tside;
  logic [1:0]       rside;

  rwsc_div #(.NW(DIV_W), .DW(DVS_W), .SW(17)) u_tdiv (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({req_i.virt_len, 12'b0}),
    .divisor_i  (req_i.phys_len),
    .side_i     ({req_i.virt_len, req_i.phys_len == 16'd0}),
    .quotient_o (tq),
    .side_o     (tside)
  );

  rwsc_div #(.NW(DIV_W), .DW(DVS_W), .SW(2)) u_rdiv (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({1'b0, vmag, 12'b0}),
    .divisor_i  ({1'b0, pmag}),
    .side_i     ({vr2[16] ^ pr2[16], pr2 == 17'sd0}),
    .quotient_o (rq),
    .side_o     (rside)
  );

  logic [DIV_W-1:0] div_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else if (en) begin
      div_vld_q <= {div_vld_q[DIV_W-2:0], req_i.valid};
    end
  end

  // Gains, saturation and dead-zone distances.
  logic [15:0]        tg, rmag;
  logic signed [17:0] rg, rlo_s, rhi_s, rdiff;
  logic [15:0]        td_d;
  logic [16:0]        rd_d;
  logic               tsat, rsat;
  always_comb begin
    tsat  = tside[0] || (|tq[DIV_W-1:16]);
    tg    = tsat ? GAIN_MAX : tq[15:0];
    rmag  = (|rq[DIV_W-1:16]) ? GAIN_MAX : rq[15:0];
    rsat  = rside[0] || (|rq[DIV_W-1:16]);
    rg    = rside[0] ? {2'b0, GAIN_MAX} : (rside[1] ? -$signed({2'b0, rmag})
                                                    : $signed({2'b0, rmag}));
    rlo_s = $signed({2'b0, rot_lo_q});
    rhi_s = $signed({2'b0, rot_hi_q});
    priority if (tg > trans_hi_q) begin
      td_d = tg - trans_hi_q;
    end else if (tg < trans_lo_q) begin
      td_d = trans_lo_q - tg;
    end else begin
      td_d = '0;
    end
    priority if (rg > rhi_s) begin
      rdiff = rg - rhi_s;
    end else if (rg < rlo_s) begin
      rdiff = rlo_s - rg;
    end else begin
      rdiff = '0;
    end
    rd_d = rdiff[16:0];
  end

  logic        b_vld_q, c_vld_q, d_vld_q;
  logic [15:0] td_q, vlen_b_q, vlen_c_q;
  logic [16:0] rd_q;
  logic        sat_b_q, sat_c_q, sat_d_q, sat_out_q;
  logic [31:0] tsq_q, tterm_q, cost_q;
  logic [33:0] rsq_q;
  logic [25:0] rterm_q;
  logic [47:0] tprod;
  logic [32:0] c1, c2;
  logic [31:0] c1s, c2s;

  assign tprod = 48'(tsq_q) * 48'(vlen_c_q);
  assign c1    = {1'b0, reset_p_q} + {1'b0, tterm_q};
  assign c2    = {7'b0, rterm_q} + {1'b0, tterm_q};
  assign c1s   = c1[32] ? COST_MAX : c1[31:0];
  assign c2s   = c2[32] ? COST_MAX : c2[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q   <= div_vld_q[DIV_W-1];
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      td_q      <= td_d;
      rd_q      <= rd_d;
      vlen_b_q  <= tside[16:1];
      sat_b_q   <= tsat || rsat;
      tsq_q     <= 32'(td_q) * 32'(td_q);
      rsq_q     <= 34'(rd_q) * 34'(rd_q);
      vlen_c_q  <= vlen_b_q;
      sat_c_q   <= sat_b_q;
      tterm_q   <= tprod[47:16];
      rterm_q   <= rsq_q[33:8];
      sat_d_q   <= sat_c_q;
      cost_q    <= (c1s < c2s) ? c1s : c2s;
      sat_out_q <= sat_d_q || c1[32] || c2[32];
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.step_cost = cost_q;
  assign res_o.saturated = sat_out_q;

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !req_i.ready)
    else $error("Request accepted while the result is stalled.");
  a_drop_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(res_o.valid) |-> $past(res_o.ready))
    else $error("Result valid dropped without being taken.");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.step_cost)
                                    && $stable(res_o.saturated))
    else $error("Stalled result changed before being taken.");
`endif

endmodule

// ===== tb/redirected_walk_step_cost_top_tb.sv =====
// Testbench of the step cost pipeline: directed and random steps checked against a predictor.
module redirected_walk_step_cost_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwsc_pkg::*;

  typedef struct {
    logic signed [14:0] vh;
    logic signed [14:0] ph;
    logic [15:0]        vlen;
    logic signed [14:0] vsh;
    logic [15:0]        plen;
    logic signed [14:0] psh;
  } step_t;

  typedef struct {
    logic [31:0] cost;
    logic        sat;
  } cost_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  rwsc_req_if req_ch ();
  rwsc_res_if res_ch ();

  redirected_walk_step_cost_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  logic [15:0] trans_lo;
  logic [15:0] trans_hi;
  logic [15:0] rot_lo;
  logic [15:0] rot_hi;
  logic [31:0] reset_pen;

  cost_t exp_costs[$];
  int    mismatches;
  bit    gaps_on;
  int    burst_left;
  int    rx_mode;
  bit    hold_off_req;
  int    hold_left;
  int    rx_phase;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint band_sq(longint gain, longint lo, longint hi);
    longint d;
    if (gain > hi) d = gain - hi;
    else if (gain < lo) d = lo - gain;
    else d = 0;
    return d * d;
  endfunction

  function automatic cost_t predict_step_cost(step_t s);
    longint tg, rg, vr, pr, tterm, rterm, c1, c2;
    cost_t  r;
    r.sat = 1'b0;
    if (s.plen == 16'd0) begin
      tg = 65535;
      r.sat = 1'b1;
    end else begin
      tg = (longint'(s.vlen) << 12) / longint'(s.plen);
      if (tg > 65535) begin
        tg = 65535;
        r.sat = 1'b1;
      end
    end
    tterm = (band_sq(tg, trans_lo, trans_hi) * longint'(s.vlen)) >> 16;
    vr = longint'(s.vsh) - longint'(s.vh);
    pr = longint'(s.psh) - longint'(s.ph);
    if (vr < 0) vr += 12868;
    if (pr < 0) pr += 12868;
    if (vr > 6434) begin
      vr = 12868 - vr;
      pr = 12868 - pr;
    end
    if (pr == 0) begin
      rg = 65535;
      r.sat = 1'b1;
    end else begin
      rg = (vr * 4096) / pr;
      if (rg > 65535) begin
        rg = 65535;
        r.sat = 1'b1;
      end else if (rg < -65535) begin
        rg = -65535;
        r.sat = 1'b1;
      end
    end
    rterm = band_sq(rg, rot_lo, rot_hi) >> 8;
    c1 = longint'(reset_pen) + tterm;
    c2 = rterm + tterm;
    if (c1 > 64'hFFFF_FFFF) begin
      c1 = 64'hFFFF_FFFF;
      r.sat = 1'b1;
    end
    if (c2 > 64'hFFFF_FFFF) begin
      c2 = 64'hFFFF_FFFF;
      r.sat = 1'b1;
    end
    r.cost = (c1 < c2) ? c1[31:0] : c2[31:0];
    return r;
  endfunction

  function automatic step_t mk(int vh, int ph, int vlen, int vsh, int plen, int psh);
    step_t s;
    s.vh = 15'(vh);
    s.ph = 15'(ph);
    s.vlen = 16'(vlen);
    s.vsh = 15'(vsh);
    s.plen = 16'(plen);
    s.psh = 15'(psh);
    return s;
  endfunction

  function automatic int rand_heading();
    return int'($urandom_range(0, 25736)) - 12868;
  endfunction

  function automatic int near_heading(int h);
    int v;
    v = h + int'($urandom_range(0, 4000)) - 2000;
    if (v > 12868) v = 12868;
    if (v < -12868) v = -12868;
    return v;
  endfunction

  // Mostly plausible steps with gains near the bands, the rest raw noise.
  function automatic step_t rand_step();
    step_t s;
    int    vl, vh, ph;
    if ($urandom_range(0, 3) == 0) begin
      s = mk(rand_heading(), rand_heading(), $urandom_range(0, 65535), rand_heading(),
             $urandom_range(0, 65535), rand_heading());
      if ($urandom_range(0, 9) == 0) s.plen = 16'd0;
    end else begin
      vl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 2048);
      vh = rand_heading();
      ph = rand_heading();
      s = mk(vh, ph, vl, near_heading(vh), (vl * int'($urandom_range(2800, 5600))) / 4096,
             near_heading(ph));
      if ($urandom_range(0, 15) == 0) s.psh = s.ph;
    end
    return s;
  endfunction

  task automatic send_step(step_t s);
    @(negedge clk_i);
    req_ch.valid = 1'b1;
    req_ch.virt_heading = s.vh;
    req_ch.phys_heading = s.ph;
    req_ch.virt_len = s.vlen;
    req_ch.virt_step_heading = s.vsh;
    req_ch.phys_len = s.plen;
    req_ch.phys_step_heading = s.psh;
    do @(posedge clk_i); while (!req_ch.ready);
    exp_costs.push_back(predict_step_cost(s));
    if (gaps_on) begin
      if (burst_left == 0) begin
        @(negedge clk_i);
        req_ch.valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    wait (exp_costs.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_TRANS_LO: trans_lo = data[15:0];
      REG_TRANS_HI: trans_hi = data[15:0];
      REG_ROT_LO:   rot_lo = data[15:0];
      REG_ROT_HI:   rot_hi = data[15:0];
      REG_RESET_P:  reset_pen = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_bands(int tl, int th, int rl, int rh, logic [31:0] rp);
    drain();
    write_reg(REG_TRANS_LO, tl);
    write_reg(REG_TRANS_HI, th);
    write_reg(REG_ROT_LO, rl);
    write_reg(REG_ROT_HI, rh);
    write_reg(REG_RESET_P, rp);
  endtask

  task automatic send_random(int n);
    repeat (n) send_step(rand_step());
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    rx_mode = 0;
    send_step(mk(-12868, -12868, 0, 12868, 0, 12868));
    send_step(mk(12868, 12868, 65535, -12868, 0, -12868));
    send_step(mk(0, 0, 65535, 1000, 1, 900));
    send_step(mk(0, 0, 256, 3000, 256, 3000));
    send_step(mk(0, 100, 300, 6434, 256, 100));
    send_step(mk(0, 0, 300, 6434, 256, 6000));
    send_step(mk(0, 0, 300, 6435, 256, 6000));
    send_step(mk(5000, 0, 256, 1000, 256, -500));
    send_step(mk(0, 1, 256, 6000, 256, -12868));
    send_step(mk(0, 12868, 256, 6000, 256, -12868));
    send_step(mk(-12868, 12868, 65535, 12868, 65535, -12868));
    send_step(mk(12868, -12868, 1, -12868, 65535, 12868));
    send_step(mk(100, 200, 16384, 150, 1, 201));
    send_step(mk(0, 0, 4000, 7000, 3000, 12000));
    send_step(mk(-8192, 8191, 21845, -4097, 43690, 16383 - 3515));
    send_step(mk(-1, -2, 32768, -16 + 12868, 32767, 3));
    rx_mode = 1;
    send_step(mk(0, 0, 65535, 0, 65535, 0));
    send_step(mk(0, 0, 0, 0, 0, 0));
    gaps_on = 1'b1;
    send_step(mk(-12868, 12868, 1000, 0, 3000, 0));
    send_step(mk(3000, -3000, 20000, 9000, 10000, -9000));
  endtask

  task automatic test_default_bands();
    gaps_on = 1'b1;
    rx_mode = 1;
    send_random(200);
    gaps_on = 1'b0;
    rx_mode = 0;
    send_random(150);
    gaps_on = 1'b1;
    rx_mode = 2;
    send_random(200);
  endtask

  task automatic test_band_extremes();
    set_bands(0, 65535, 0, 65535, 0);
    send_random(100);
    set_bands(65535, 0, 65535, 0, 32'hFFFF_FFFF);
    send_random(120);
    set_bands(0, 0, 0, 0, 32'hFFFF_FFFF);
    send_random(100);
    set_bands(65535, 65535, 65535, 65535, 32'd1);
    send_random(80);
    set_bands($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
    send_random(100);
  endtask

  task automatic test_output_backpressure();
    set_bands(int'(TRANS_LO_RST), int'(TRANS_HI_RST), int'(ROT_LO_RST), int'(ROT_HI_RST),
              RESET_P_RST);
    gaps_on = 1'b0;
    rx_mode = 1;
    hold_off_req = 1'b1;
    send_random(200);
    gaps_on = 1'b1;
    send_random(180);
  endtask

  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        0: res_ch.ready = 1'b1;
        1: res_ch.ready = ($urandom_range(0, 2) != 0);
        default: res_ch.ready = (rx_phase % 7) > 2;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cost_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (exp_costs.size() == 0) begin
        $error("step_cost result with no request pending: %0d", res_ch.step_cost);
        mismatches++;
      end else begin
        want = exp_costs.pop_front();
        if (res_ch.step_cost !== want.cost) begin
          $error("step_cost expected %0d actual %0d", want.cost, res_ch.step_cost);
          mismatches++;
        end
        if (res_ch.saturated !== want.sat) begin
          $error("saturated expected %0d actual %0d", want.sat, res_ch.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.virt_heading = '0;
    req_ch.phys_heading = '0;
    req_ch.virt_len = '0;
    req_ch.virt_step_heading = '0;
    req_ch.phys_len = '0;
    req_ch.phys_step_heading = '0;
    res_ch.ready = 1'b0;
    trans_lo = TRANS_LO_RST;
    trans_hi = TRANS_HI_RST;
    rot_lo = ROT_LO_RST;
    rot_hi = ROT_HI_RST;
    reset_pen = RESET_P_RST;
    mismatches = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    rx_mode = 0;
    hold_off_req = 1'b0;
    hold_left = 0;
    rx_phase = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_default_bands();
    test_band_extremes();
    test_output_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
